@@ hdl/pstr_pkg.sv @@
// Shared types and constants of the power state residency tracker.
package pstr_pkg;

	localparam int MODE_W      = 2;
	localparam int CPU_W       = 1;
	localparam int STATE_W     = 3;
	localparam int TS_W        = 63;
	localparam int TIME_W      = 64;
	localparam int CNT_W       = 32;
	localparam int CODE_W      = 4;
	localparam int CFG_IDX_W   = 1;
	// wide enough to compare CPU numbers against the CPU count
	localparam int CPU_CMP_W   = 4;
	localparam int STATE_IDX_W = 5;

	typedef enum logic [MODE_W-1:0] {
		MODE_LOG   = 2'd0,
		MODE_CLEAR = 2'd1,
		MODE_READ  = 2'd2,
		MODE_NOP   = 2'd3
	} mode_t;

	localparam logic [CFG_IDX_W-1:0] REG_RUNNING = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WFI     = 1'd1;

	localparam logic [CODE_W-1:0] RUNNING_RESET = 4'd0;
	localparam logic [CODE_W-1:0] WFI_RESET     = 4'd1;

endpackage

@@ hdl/pstr_ifs.sv @@
// Valid/ready channel interfaces for event items and read results.
interface pstr_in_if;
	logic                           valid;
	logic                           ready;
	logic [pstr_pkg::MODE_W-1:0]    mode;
	logic [pstr_pkg::CPU_W-1:0]     cpu_index;
	logic [pstr_pkg::STATE_W-1:0]   power_state;
	logic [pstr_pkg::TS_W-1:0]      timestamp;

	modport source (output valid, mode, cpu_index, power_state, timestamp, input ready);
	modport sink (input valid, mode, cpu_index, power_state, timestamp, output ready);
endinterface

interface pstr_out_if;
	logic                           valid;
	logic                           ready;
	logic [pstr_pkg::STATE_W-1:0]   cpu_state_now;
	logic [pstr_pkg::CNT_W-1:0]     entry_count_value;
	logic [pstr_pkg::TIME_W-1:0]    residency_value;

	modport source (output valid, cpu_state_now, entry_count_value, residency_value, input ready);
	modport sink (input valid, cpu_state_now, entry_count_value, residency_value, output ready);
endinterface

@@ hdl/power_state_residency_tracker_top.sv @@
// Power state residency tracker: per-CPU state, entry counts and residency times.
//
// Items arrive on in_ch (mode, cpu_index, power_state, timestamp). A log item
// moves a CPU to a new state and aligns the other CPUs, a clear item zeroes
// all statistics and puts every CPU in the running state, a read item yields
// one result on out_ch with the CPU's current state and its count and time
// for the requested state. Log, clear and no-op items give no result.
// An item is registered on acceptance and processed from the input register;
// all count and time cells update in parallel, each with its own adder, so
// one item is taken every cycle unless a stalled read holds intake. A read
// result goes from the input register to the output register and out_ch.
// When the receiver stalls, the result waits in the output register; log,
// clear and no-op items keep passing through the input register, but the
// next read is held there and stops intake until the output register frees up.
// running_code and wfi_code must be written through cfg_we/cfg_index/cfg_data
// only while idle, not enforced by the block; only their low three bits take part.
// Reset clears all counts and times, sets CPU 0 to running and the others
// to WFI (reset codes), and empties both registers.
module power_state_residency_tracker_top #(
	parameter int NUM_CPUS   = 2,
	parameter int NUM_STATES = 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [pstr_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [pstr_pkg::CODE_W-1:0]       cfg_data,
	pstr_in_if.sink                           in_ch,
	pstr_out_if.source                        out_ch
);

	localparam int SW  = pstr_pkg::STATE_W;
	localparam int CW  = pstr_pkg::CPU_CMP_W;
	localparam int XW  = pstr_pkg::STATE_IDX_W;
	localparam int TW  = pstr_pkg::TIME_W;
	localparam int NW  = pstr_pkg::CNT_W;

	logic [pstr_pkg::CODE_W-1:0]  run_code_q;
	logic [pstr_pkg::CODE_W-1:0]  wfi_code_q;

	logic                         s1_valid_q;
	pstr_pkg::mode_t              mode_s1;
	logic [pstr_pkg::CPU_W-1:0]   cpu_s1;
	logic [SW-1:0]                ps_s1;
	logic [pstr_pkg::TS_W-1:0]    ts_s1;

	logic [SW-1:0]  cur_q  [NUM_CPUS];
	logic [TW-1:0]  last_q [NUM_CPUS];
	logic [NW-1:0]  cnt_q  [NUM_CPUS][NUM_STATES];
	logic [TW-1:0]  res_q  [NUM_CPUS][NUM_STATES];

	logic           out_valid_q;
	logic [SW-1:0]  out_state_q;
	logic [NW-1:0]  out_cnt_q;
	logic [TW-1:0]  out_res_q;

	logic [SW-1:0]  run;
	logic [SW-1:0]  wfi;
	logic           is_log;
	logic           is_clear;
	logic           is_read;
	logic [CW-1:0]  cpu_ext;
	logic           cpu_ok;
	logic [SW-1:0]  self_state;
	logic           log_ok;
	logic [TW-1:0]  now;
	logic           move   [NUM_CPUS];
	logic [SW-1:0]  target [NUM_CPUS];
	logic [TW-1:0]  delta  [NUM_CPUS];
	logic [SW-1:0]  rd_state;
	logic [NW-1:0]  rd_cnt;
	logic [TW-1:0]  rd_res;
	logic           out_free;
	logic           adv;

	assign run      = run_code_q[SW-1:0];
	assign wfi      = wfi_code_q[SW-1:0];
	assign is_log   = s1_valid_q && (mode_s1 == pstr_pkg::MODE_LOG);
	assign is_clear = s1_valid_q && (mode_s1 == pstr_pkg::MODE_CLEAR);
	assign is_read  = s1_valid_q && (mode_s1 == pstr_pkg::MODE_READ);
	assign cpu_ext  = CW'(cpu_s1);
	assign cpu_ok   = cpu_ext < CW'(NUM_CPUS);
	assign now      = TW'(ts_s1);
	assign log_ok   = is_log && cpu_ok && (self_state != ps_s1);

	assign out_free    = !out_valid_q || out_ch.ready;
	assign adv         = !is_read || out_free;
	assign in_ch.ready = !s1_valid_q || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_code_q <= pstr_pkg::RUNNING_RESET;
			wfi_code_q <= pstr_pkg::WFI_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				pstr_pkg::REG_RUNNING: run_code_q <= cfg_data;
				pstr_pkg::REG_WFI:     wfi_code_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_ch.ready) begin
			s1_valid_q <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.ready && in_ch.valid) begin
			mode_s1 <= pstr_pkg::mode_t'(in_ch.mode);
			cpu_s1  <= in_ch.cpu_index;
			ps_s1   <= in_ch.power_state;
			ts_s1   <= in_ch.timestamp;
		end
	end

	always_comb begin
		self_state = '0;
		for (int c = 0; c < NUM_CPUS; c++) begin
			if (CW'(c) == cpu_ext)
				self_state = cur_q[c];
		end
	end

	// per-CPU move decision: the logging CPU takes the new state, the others
	// follow running (to WFI unless in WFI or running) or any other non-WFI state
	always_comb begin
		for (int c = 0; c < NUM_CPUS; c++) begin
			delta[c] = now - last_q[c];
			if (CW'(c) == cpu_ext) begin
				move[c]   = log_ok;
				target[c] = ps_s1;
			end else begin
				target[c] = (ps_s1 == run) ? wfi : ps_s1;
				move[c]   = log_ok && (ps_s1 != wfi) && (cur_q[c] != ps_s1) &&
				            ((ps_s1 != run) || (cur_q[c] != wfi));
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < NUM_CPUS; c++) begin
				cur_q[c]  <= (c == 0) ? pstr_pkg::RUNNING_RESET[SW-1:0]
				                      : pstr_pkg::WFI_RESET[SW-1:0];
				last_q[c] <= '0;
			end
		end else if (is_clear) begin
			for (int c = 0; c < NUM_CPUS; c++) begin
				cur_q[c]  <= run;
				last_q[c] <= now;
			end
		end else begin
			for (int c = 0; c < NUM_CPUS; c++) begin
				if (move[c]) begin
					cur_q[c]  <= target[c];
					last_q[c] <= now;
				end
			end
		end
	end

	// each cell adds for itself: time when its state is left, count when entered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < NUM_CPUS; c++) begin
				for (int s = 0; s < NUM_STATES; s++) begin
					cnt_q[c][s] <= '0;
					res_q[c][s] <= '0;
				end
			end
		end else if (is_clear) begin
			for (int c = 0; c < NUM_CPUS; c++) begin
				for (int s = 0; s < NUM_STATES; s++) begin
					cnt_q[c][s] <= '0;
					res_q[c][s] <= '0;
				end
			end
		end else begin
			for (int c = 0; c < NUM_CPUS; c++) begin
				for (int s = 0; s < NUM_STATES; s++) begin
					if (move[c] && (XW'(cur_q[c]) == XW'(s)))
						res_q[c][s] <= res_q[c][s] + delta[c];
					if (move[c] && (XW'(target[c]) == XW'(s)))
						cnt_q[c][s] <= cnt_q[c][s] + NW'(1);
				end
			end
		end
	end

	// unknown CPU or state falls through to zero
	always_comb begin
		rd_state = '0;
		rd_cnt   = '0;
		rd_res   = '0;
		for (int c = 0; c < NUM_CPUS; c++) begin
			if (CW'(c) == cpu_ext)
				rd_state = cur_q[c];
			for (int s = 0; s < NUM_STATES; s++) begin
				if ((CW'(c) == cpu_ext) && (XW'(s) == XW'(ps_s1))) begin
					rd_cnt = cnt_q[c][s];
					rd_res = res_q[c][s];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= is_read;
		end
	end

	always_ff @(posedge clk) begin
		if (is_read && out_free) begin
			out_state_q <= rd_state;
			out_cnt_q   <= rd_cnt;
			out_res_q   <= rd_res;
		end
	end

	assign out_ch.valid             = out_valid_q;
	assign out_ch.cpu_state_now     = out_state_q;
	assign out_ch.entry_count_value = out_cnt_q;
	assign out_ch.residency_value   = out_res_q;

`ifndef NO_ASSERTIONS
	a_clear_sets_running: assert property (@(posedge clk) disable iff (!arst_n)
		is_clear |=> cur_q[0] == $past(run_code_q[SW-1:0]))
		else $error("clear did not set CPU 0 to the running code");

	a_stalled_read_held: assert property (@(posedge clk) disable iff (!arst_n)
		(is_read && !out_free) |=> is_read)
		else $error("stalled read item left the input register");

	a_other_items_flow: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_q && !is_read) |-> in_ch.ready)
		else $error("non-read item blocked intake");

	a_result_from_read: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(is_read))
		else $error("result raised without a read item");
`endif

endmodule

@@ tb/pstr_residency_audit.sv @@
// Predicts tracker reads from observed events and config writes, and checks every result.
module pstr_residency_audit
	import pstr_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CODE_W-1:0]    cfg_data,
	pstr_in_if                   evt,
	pstr_out_if                  rpt,
	output int                   fail_count,
	output int                   reads_pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CPUS   = 2;
	localparam int STATES = 8;

	typedef struct packed {
		logic [STATE_W-1:0] st;
		logic [CNT_W-1:0]   cnt;
		logic [TIME_W-1:0]  res;
	} read_expect_t;

	logic [CODE_W-1:0]  running_reg;
	logic [CODE_W-1:0]  wfi_reg;
	logic [STATE_W-1:0] cur_state [CPUS];
	logic [TIME_W-1:0]  last_change [CPUS];
	logic [CNT_W-1:0]   entries [CPUS][STATES];
	logic [TIME_W-1:0]  residency [CPUS][STATES];

	read_expect_t expected_reads [$];
	int           mismatches = 0;

	assign fail_count = mismatches;

	function automatic void clear_stats();
		for (int c = 0; c < CPUS; c++)
			for (int s = 0; s < STATES; s++) begin
				entries[c][s]   = '0;
				residency[c][s] = '0;
			end
	endfunction

	// close the old state's time, count the new one
	function automatic void move_cpu_state(int c, logic [STATE_W-1:0] nxt, logic [TIME_W-1:0] t);
		residency[c][cur_state[c]] += t - last_change[c];
		last_change[c] = t;
		cur_state[c]   = nxt;
		entries[c][nxt] += 1;
	endfunction

	function automatic void log_state_change(int c, logic [STATE_W-1:0] ps,
			logic [TIME_W-1:0] t);
		logic [STATE_W-1:0] run_st;
		logic [STATE_W-1:0] wfi_st;
		run_st = running_reg[STATE_W-1:0];
		wfi_st = wfi_reg[STATE_W-1:0];
		if (cur_state[c] == ps)
			return;
		move_cpu_state(c, ps, t);
		if (ps == wfi_st)
			return;
		for (int o = 0; o < CPUS; o++) begin
			if (o == c || cur_state[o] == ps)
				continue;
			// going to running pushes only CPUs outside running and WFI into WFI
			if (ps == run_st) begin
				if (cur_state[o] != wfi_st)
					move_cpu_state(o, wfi_st, t);
			end else begin
				move_cpu_state(o, ps, t);
			end
		end
	endfunction

	function automatic void note_mismatch(string what, logic [TIME_W-1:0] want,
			logic [TIME_W-1:0] got);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t mismatch on %s: expected %0h, got %0h", $realtime, what, want, got);
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		read_expect_t want;
		logic [TIME_W-1:0] stamp;
		if (!arst_n) begin
			running_reg = RUNNING_RESET;
			wfi_reg     = WFI_RESET;
			for (int c = 0; c < CPUS; c++) begin
				cur_state[c]   = (c == 0) ? RUNNING_RESET[STATE_W-1:0] : WFI_RESET[STATE_W-1:0];
				last_change[c] = '0;
			end
			clear_stats();
			expected_reads.delete();
			reads_pending <= 0;
		end else begin
			if (rpt.valid && rpt.ready) begin
				if (expected_reads.size() == 0) begin
					note_mismatch("unexpected result, state", '0, rpt.cpu_state_now);
				end else begin
					want = expected_reads.pop_front();
					if (rpt.cpu_state_now !== want.st)
						note_mismatch("cpu_state_now", want.st, rpt.cpu_state_now);
					if (rpt.entry_count_value !== want.cnt)
						note_mismatch("entry_count_value", want.cnt, rpt.entry_count_value);
					if (rpt.residency_value !== want.res)
						note_mismatch("residency_value", want.res, rpt.residency_value);
				end
			end
			if (cfg_we) begin
				if (cfg_index == REG_RUNNING)
					running_reg = cfg_data;
				else if (cfg_index == REG_WFI)
					wfi_reg = cfg_data;
			end
			if (evt.valid && evt.ready) begin
				stamp = {1'b0, evt.timestamp};
				case (mode_t'(evt.mode))
					MODE_LOG: begin
						log_state_change(int'(evt.cpu_index), evt.power_state, stamp);
					end
					MODE_CLEAR: begin
						clear_stats();
						for (int c = 0; c < CPUS; c++) begin
							last_change[c] = stamp;
							cur_state[c]   = running_reg[STATE_W-1:0];
						end
					end
					MODE_READ: begin
						want.st  = cur_state[evt.cpu_index];
						want.cnt = entries[evt.cpu_index][evt.power_state];
						want.res = residency[evt.cpu_index][evt.power_state];
						expected_reads.push_back(want);
					end
					default: ;
				endcase
			end
			reads_pending <= expected_reads.size();
		end
	end

endmodule

@@ tb/power_state_residency_tracker_top_tb.sv @@
// Stimulus, reset, clocking and verdict for the power state residency tracker.
module power_state_residency_tracker_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import pstr_pkg::*;

	localparam int IDLE_LIMIT = 2000;
	localparam int PHASES     = 8;
	localparam int PHASE_LEN  = 135;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CODE_W-1:0]    cfg_data;

	int fail_count;
	int reads_pending;

	logic              sender_calm;
	logic              sink_calm;
	logic [CODE_W-1:0] run_code;
	logic [CODE_W-1:0] wfi_code;
	logic [TS_W-1:0]   now_ns;

	pstr_in_if  evt_ch ();
	pstr_out_if rpt_ch ();

	power_state_residency_tracker_top #(
		.NUM_CPUS(2),
		.NUM_STATES(8)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_ch(evt_ch),
		.out_ch(rpt_ch)
	);

	pstr_residency_audit audit (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.evt(evt_ch),
		.rpt(rpt_ch),
		.fail_count(fail_count),
		.reads_pending(reads_pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// mostly short idle stretches, now and then a long one
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(11, 40);
	endfunction

	function automatic logic [TS_W-1:0] ts_pick();
		int r;
		logic [TS_W-1:0] t;
		r = $urandom_range(0, 99);
		if (r < 80) begin
			now_ns += TS_W'($urandom_range(1, 2000));
			t = now_ns;
		end else if (r < 85) begin
			now_ns += TS_W'($urandom) << $urandom_range(0, 30);
			t = now_ns;
		end else if (r < 90) begin
			// earlier than the latest timestamp, so the difference can wrap
			t = now_ns - TS_W'($urandom_range(1, 5000));
		end else if (r < 95) begin
			t = {TS_W{1'b1}} - TS_W'($urandom_range(0, 100));
			now_ns = t;
		end else begin
			t = TS_W'({$urandom, $urandom});
		end
		return t;
	endfunction

	function automatic logic [STATE_W-1:0] state_pick();
		int r;
		r = $urandom_range(0, 99);
		if (r < 25)
			return run_code[STATE_W-1:0];
		if (r < 45)
			return wfi_code[STATE_W-1:0];
		return STATE_W'($urandom_range(0, 7));
	endfunction

	// drives the item, then waits while the tracker holds ready low
	task automatic send_evt(input mode_t m, input logic cpu, input logic [STATE_W-1:0] ps,
			input logic [TS_W-1:0] ts);
		int gap;
		gap = 0;
		if (!sender_calm && $urandom_range(0, 99) < 40)
			gap = idle_len();
		if (gap > 0) begin
			evt_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		evt_ch.valid       <= 1'b1;
		evt_ch.mode        <= m;
		evt_ch.cpu_index   <= cpu;
		evt_ch.power_state <= ps;
		evt_ch.timestamp   <= ts;
		@(posedge clk);
		while (!evt_ch.ready)
			@(posedge clk);
	endtask

	// hold off until every read has come back and the last log item has settled
	task automatic wait_idle(input int settle);
		evt_ch.valid <= 1'b0;
		@(posedge clk);
		while (reads_pending != 0)
			@(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	task automatic set_codes(input logic [CODE_W-1:0] run, input logic [CODE_W-1:0] wfi);
		cfg_we    <= 1'b1;
		cfg_index <= REG_RUNNING;
		cfg_data  <= run;
		@(posedge clk);
		cfg_index <= REG_WFI;
		cfg_data  <= wfi;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		run_code = run;
		wfi_code = wfi;
	endtask

	task automatic random_item();
		int r;
		logic cpu;
		r   = $urandom_range(0, 99);
		cpu = 1'($urandom_range(0, 1));
		if (r < 58)
			send_evt(MODE_LOG, cpu, state_pick(), ts_pick());
		else if (r < 88)
			send_evt(MODE_READ, cpu, STATE_W'($urandom_range(0, 7)),
				TS_W'({$urandom, $urandom}));
		else if (r < 93)
			send_evt(MODE_CLEAR, cpu, STATE_W'($urandom_range(0, 7)), ts_pick());
		else
			send_evt(MODE_NOP, cpu, STATE_W'($urandom_range(0, 7)),
				TS_W'({$urandom, $urandom}));
	endtask

	// result side: random stalls unless the sink is in a calm stretch
	initial begin : result_sink
		int stall;
		stall = 0;
		rpt_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (!arst_n) begin
				rpt_ch.ready <= 1'b0;
			end else if (stall > 0) begin
				rpt_ch.ready <= 1'b0;
				stall--;
			end else if (!sink_calm && $urandom_range(0, 99) < 25) begin
				rpt_ch.ready <= 1'b0;
				stall = idle_len() - 1;
			end else begin
				rpt_ch.ready <= 1'b1;
			end
		end
	end

	initial begin : watchdog
		int idle;
		idle = 0;
		while (idle < IDLE_LIMIT) begin
			@(posedge clk);
			if ((evt_ch.valid && evt_ch.ready) || (rpt_ch.valid && rpt_ch.ready))
				idle = 0;
			else
				idle++;
		end
		$display("power_state_residency_tracker_top regression: fail");
		$finish;
	end

	initial begin : stimulus
		logic [CODE_W-1:0] run_pick;
		logic [CODE_W-1:0] wfi_pick;
		arst_n             = 1'b0;
		cfg_we             = 1'b0;
		cfg_index          = REG_RUNNING;
		cfg_data           = '0;
		evt_ch.valid       = 1'b0;
		evt_ch.mode        = MODE_NOP;
		evt_ch.cpu_index   = '0;
		evt_ch.power_state = '0;
		evt_ch.timestamp   = '0;
		sender_calm        = 1'b0;
		sink_calm          = 1'b0;
		run_code           = RUNNING_RESET;
		wfi_code           = WFI_RESET;
		now_ns             = TS_W'(2000);
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset codes, running 0 and WFI 1
		send_evt(MODE_READ, 1'b0, 3'd0, {TS_W{1'b1}});
		send_evt(MODE_READ, 1'b1, 3'd7, '0);
		send_evt(MODE_LOG, 1'b1, 3'd0, TS_W'(100));
		send_evt(MODE_LOG, 1'b0, 3'd5, TS_W'(250));
		send_evt(MODE_LOG, 1'b0, 3'd5, TS_W'(300));     // repeat, ignored
		send_evt(MODE_LOG, 1'b1, 3'd1, TS_W'(400));     // WFI leaves cpu 0 alone
		send_evt(MODE_LOG, 1'b0, 3'd0, TS_W'(700));     // running, cpu 1 stays in WFI
		send_evt(MODE_LOG, 1'b1, 3'd3, TS_W'(900));
		send_evt(MODE_LOG, 1'b0, 3'd0, TS_W'(1000));    // running, cpu 1 pushed to WFI
		send_evt(MODE_NOP, 1'b1, 3'd7, {TS_W{1'b1}});
		send_evt(MODE_READ, 1'b0, 3'd5, '0);
		send_evt(MODE_READ, 1'b1, 3'd3, '0);
		send_evt(MODE_READ, 1'b0, 3'd0, '0);
		send_evt(MODE_LOG, 1'b1, 3'd6, {TS_W{1'b1}});
		send_evt(MODE_LOG, 1'b0, 3'd2, TS_W'(5));       // time runs backward
		send_evt(MODE_READ, 1'b0, 3'd2, '0);
		send_evt(MODE_READ, 1'b1, 3'd6, '0);
		send_evt(MODE_READ, 1'b0, 3'd6, '0);
		send_evt(MODE_CLEAR, 1'b1, 3'd4, TS_W'(63'h7FFF_FFFF_FFFF_FFF0));
		send_evt(MODE_READ, 1'b1, 3'd0, '0);
		send_evt(MODE_LOG, 1'b0, 3'd7, TS_W'(3));
		send_evt(MODE_READ, 1'b0, 3'd0, '0);
		send_evt(MODE_READ, 1'b1, 3'd7, '0);

		for (int ph = 0; ph < PHASES; ph++) begin
			wait_idle(4);
			case (ph)
				0: begin run_pick = 4'd15; wfi_pick = 4'd0;  end
				1: begin run_pick = 4'd0;  wfi_pick = 4'd15; end
				2: begin run_pick = 4'd5;  wfi_pick = 4'd5;  end
				3: begin run_pick = 4'd8;  wfi_pick = 4'd9;  end
				default: begin
					run_pick = CODE_W'($urandom_range(0, 15));
					wfi_pick = CODE_W'($urandom_range(0, 15));
				end
			endcase
			set_codes(run_pick, wfi_pick);
			sender_calm = (ph == 1 || ph == 2) ? 1'b1 :
				(ph == 3) ? 1'b0 : ($urandom_range(0, 3) == 0);
			sink_calm = (ph == 1 || ph == 4) ? 1'b1 :
				(ph == 3) ? 1'b0 : ($urandom_range(0, 3) == 0);
			for (int i = 0; i < PHASE_LEN; i++) begin
				if ($urandom_range(0, 99) == 0)
					wait_idle(0);
				random_item();
			end
		end

		wait_idle(10);
		if (fail_count == 0 && reads_pending == 0)
			$display("power_state_residency_tracker_top regression: pass");
		else
			$display("power_state_residency_tracker_top regression: fail");
		$finish;
	end

endmodule
